/* src/ftrl_pkg.sv */
// Shared types, register codes and Q16.16 helpers for the FTRL weight engine.
// No dependencies; every other file of the block imports this package.
package ftrl_pkg;

  localparam int unsigned IDX_W      = 10;
  localparam int unsigned Q_W        = 32;
  localparam int unsigned CFG_W      = 31;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned DIV_STEPS  = 64;

  localparam logic signed [63:0] QMAX64 = 64'sd2147483647;
  localparam logic signed [63:0] QMIN64 = -64'sd2147483648;
  localparam logic signed [31:0] QMAX32 = 32'sh7fffffff;
  localparam logic signed [31:0] QMIN32 = 32'sh80000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_L1   = 2'd0,
    REG_L2   = 2'd1,
    REG_LR   = 2'd2,
    REG_BETA = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic                    opcode;
    logic [IDX_W-1:0]        feature_index;
    logic signed [Q_W-1:0]   gradient;
  } in_item_t;

  typedef struct packed {
    logic signed [Q_W-1:0]   weight;
    logic                    became_nonzero;
    logic                    saturated;
  } out_item_t;

  typedef struct packed {
    logic signed [Q_W-1:0]   z;
    logic signed [Q_W-1:0]   norm;
    logic signed [Q_W-1:0]   w;
  } entry_t;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // Product / 65536, truncated toward zero.
  function automatic logic signed [63:0] qtrunc16(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p >>> 16;
    if (p[63] && (p[15:0] != 16'd0)) begin
      s = s + 64'sd1;
    end
    return s;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > QMAX64) begin
      r = QMAX32;
    end else if (v < QMIN64) begin
      r = QMIN32;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic ovf32(input logic signed [63:0] v);
    return (v > QMAX64) || (v < QMIN64);
  endfunction

endpackage

/* src/ftrl_table.sv */
// Per-feature state memory: z, gradient norm and weight in one wide word.
// Uses ftrl_pkg for the entry type; one write port, one registered read port.
module ftrl_table #(
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  ftrl_pkg::entry_t    wdata_i,
  input  logic                re_i,
  input  logic [AW-1:0]       raddr_i,
  output ftrl_pkg::entry_t    rdata_o
);
  import ftrl_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/ftrl_sqrt.sv */
// Digit-by-digit floor square root of a 64-bit radicand, two bits per cycle.
// Uses ftrl_pkg for the step count; done pulses one cycle with the root.
module ftrl_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] radicand_i,
  output logic        done_o,
  output logic [31:0] root_o
);
  import ftrl_pkg::*;

  logic        busy_q;
  logic        done_q;
  logic [4:0]  cnt_q;
  logic [63:0] v_q;
  logic [33:0] rem_q;
  logic [31:0] root_q;

  logic [33:0] rem_sh;
  logic [33:0] trial;
  logic        ge;

  always_comb begin
    rem_sh = {rem_q[31:0], v_q[63:62]};
    trial  = {root_q, 2'b01};
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      v_q    <= '0;
      rem_q  <= '0;
      root_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        v_q    <= radicand_i;
        rem_q  <= '0;
        root_q <= '0;
      end else if (busy_q) begin
        v_q   <= {v_q[61:0], 2'b00};
        cnt_q <= cnt_q + 5'd1;
        if (ge) begin
          rem_q  <= rem_sh - trial;
          root_q <= {root_q[30:0], 1'b1};
        end else begin
          rem_q  <= rem_sh;
          root_q <= {root_q[30:0], 1'b0};
        end
        if (cnt_q == 5'(SQRT_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

/* src/ftrl_div.sv */
// Restoring unsigned divider, 64-bit dividend by nonzero 32-bit divisor.
// Uses ftrl_pkg for the step count; one quotient bit per cycle.
module ftrl_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quotient_o
);
  import ftrl_pkg::*;

  logic        busy_q;
  logic        done_q;
  logic [5:0]  cnt_q;
  logic [63:0] dvd_q;
  logic [31:0] dvs_q;
  logic [31:0] rem_q;
  logic [63:0] quo_q;

  logic [32:0] rem_sh;
  logic [32:0] diff;
  logic        ge;

  always_comb begin
    rem_sh = {rem_q, dvd_q[63]};
    diff   = rem_sh - {1'b0, dvs_q};
    ge     = rem_sh >= {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      dvd_q  <= '0;
      dvs_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        dvd_q  <= dividend_i;
        dvs_q  <= divisor_i;
        rem_q  <= '0;
        quo_q  <= '0;
      end else if (busy_q) begin
        dvd_q <= {dvd_q[62:0], 1'b0};
        cnt_q <= cnt_q + 6'd1;
        rem_q <= ge ? diff[31:0] : rem_sh[31:0];
        quo_q <= {quo_q[62:0], ge};
        if (cnt_q == 6'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* src/ftrl_proximal_weight_update.sv */
// FTRL-proximal weight engine: sequencer, shared multiplier and state table.
// Uses ftrl_pkg, ftrl_table, ftrl_sqrt and ftrl_div.
//
// One transaction is taken at a time. After reset the block sweeps the state
// table to zero, one entry per cycle, and holds in_stall_o high meanwhile
// (configuration writes are taken as ever). The feature index is reduced
// modulo TABLE_DEPTH: a reciprocal multiply estimates the quotient, then one
// compare and subtract fixes the remainder. The entry is then read from the
// registered table port. A read transaction passes its entry straight to the
// output; the next transaction is taken once that result is loaded. An update
// also runs the bit-serial divisions (64 steps each, one shared divider;
// the second is skipped when z lies within the L1 band or its divisor is
// zero), the 32-step square root and a handful of multiply steps on one
// registered 32x32 multiplier. The result sits in an output register, so the
// next transaction is taken while a finished result still waits for the
// downstream side.
// Config registers must only be written while the block is idle.
module ftrl_proximal_weight_update #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  ftrl_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output ftrl_pkg::out_item_t                 out_data_o,
  input  logic                                cfg_we_i,
  input  logic [ftrl_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ftrl_pkg::CFG_W-1:0]          cfg_data_i
);
  import ftrl_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam logic [AW-1:0] DEPTH_LAST = AW'(TABLE_DEPTH - 1);
  // Quotient estimate: (index * floor(2^20 / depth)) >> 20 is low by at most one.
  localparam logic [19:0]   RECIP_M    = 20'((64'd1 << 20) / TABLE_DEPTH);

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_QUOT, ST_MOD, ST_READ, ST_LOAD, ST_L2MUL, ST_GW, ST_SQS,
    ST_SQG, ST_SUM, ST_SQRT_GO, ST_SQRT_WAIT, ST_DIV1_GO, ST_DIV1_WAIT,
    ST_TERM_MUL, ST_TERM, ST_ZST, ST_THR, ST_WMUL, ST_DIVW_GO, ST_DIVW_WAIT,
    ST_WFIN, ST_WRITE, ST_OUT
  } state_e;

  // Configuration registers.
  logic [CFG_W-1:0] l1_q, l2_q, lr_q, beta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_q   <= 31'd65536;
      l2_q   <= 31'd0;
      lr_q   <= 31'd3277;
      beta_q <= 31'd65536;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_L1:   l1_q   <= cfg_data_i;
        REG_L2:   l2_q   <= cfg_data_i;
        REG_LR:   lr_q   <= cfg_data_i;
        REG_BETA: beta_q <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  // A zero learning rate acts as the smallest nonzero step.
  logic [31:0] lr_eff;
  assign lr_eff = (lr_q == '0) ? 32'd1 : {1'b0, lr_q};

  // Control state and registered outputs.
  state_e        state_q;
  logic [AW-1:0] clr_q;
  logic          out_valid_q;
  out_item_t     out_q;

  // Datapath registers.
  logic                  op_q;
  logic [IDX_W-1:0]      raw_q;
  logic [IDX_W-1:0]      quot_q;
  logic [AW-1:0]         rem_q;
  logic signed [31:0]    g_q, zo_q, so_q, wo_q, gw_q, ng_q, ratio_q, term_q;
  logic signed [31:0]    z_q, zd_q, wnew_q;
  logic [31:0]           den_q;
  logic [63:0]           sq_q, rad_q;
  logic signed [63:0]    prod_q;
  logic                  sat_q, bn_q;

  // Memory, shared units.
  entry_t         rd_data;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  entry_t         mem_wdata;
  logic           sqrt_done;
  logic [31:0]    sqrt_root;
  logic           div_start;
  logic [63:0]    div_dividend;
  logic [31:0]    div_divisor;
  logic           div_done;
  logic [63:0]    div_quo;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod_d;

  // Shared multiplier operand select; product registered every cycle.
  always_comb begin
    case (state_q)
      ST_L2MUL:    begin mul_a = wo_q;    mul_b = $signed({1'b0, l2_q}); end
      ST_SQS:      begin mul_a = so_q;    mul_b = so_q;                  end
      ST_SQG:      begin mul_a = gw_q;    mul_b = gw_q;                  end
      ST_TERM_MUL: begin mul_a = ratio_q; mul_b = wo_q;                  end
      ST_WMUL:     begin mul_a = zd_q;    mul_b = $signed(lr_eff);       end
      default:     begin mul_a = '0;      mul_b = '0;                    end
    endcase
    prod_d = mul_a * mul_b;
  end

  // Index reduction: quotient estimate, then the remainder with one fix-up.
  logic [29:0] quot_prod;
  logic [30:0] mod_diff;
  assign quot_prod = 30'(raw_q) * 30'(RECIP_M);
  assign mod_diff  = 31'(raw_q) - 31'(quot_q) * 31'(TABLE_DEPTH);

  // Table access.
  assign mem_we    = (state_q == ST_CLEAR) || (state_q == ST_WRITE);
  assign mem_waddr = (state_q == ST_CLEAR) ? clr_q : rem_q;
  assign mem_wdata = (state_q == ST_CLEAR) ? entry_t'('0)
                                           : entry_t'{z: z_q, norm: ng_q, w: wnew_q};

  ftrl_table #(.DEPTH(TABLE_DEPTH)) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (state_q == ST_READ),
    .raddr_i (rem_q),
    .rdata_o (rd_data)
  );

  ftrl_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == ST_SQRT_GO),
    .radicand_i (rad_q),
    .done_o     (sqrt_done),
    .root_o     (sqrt_root)
  );

  // Divider feeds: delta/lr for the norm ratio, |zd*lr|/den for the weight.
  logic [31:0] delta;
  assign delta = ng_q - so_q;

  always_comb begin
    if (state_q == ST_DIV1_GO) begin
      div_dividend = {16'd0, delta, 16'd0};
      div_divisor  = lr_eff;
    end else begin
      div_dividend = prod_q[63] ? 64'(-prod_q) : 64'(prod_q);
      div_divisor  = den_q;
    end
  end
  assign div_start = (state_q == ST_DIV1_GO) ||
                     ((state_q == ST_DIVW_GO) && (den_q != '0));

  ftrl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Per-state arithmetic.
  logic signed [31:0] m_val, gw_val, term_val, inner_val, z_val;
  logic               m_ovf, gw_ovf, term_ovf, inner_ovf, z_ovf;
  logic signed [63:0] z64, l1_64;
  logic               in_band;

  always_comb begin
    m_val     = sat32(qtrunc16(prod_q));
    m_ovf     = ovf32(qtrunc16(prod_q));
    gw_val    = sat32(64'(g_q) + 64'(m_val));
    gw_ovf    = ovf32(64'(g_q) + 64'(m_val));
    term_val  = sat32(qtrunc16(prod_q));
    term_ovf  = ovf32(qtrunc16(prod_q));
    inner_val = sat32(64'(gw_q) - 64'(term_q));
    inner_ovf = ovf32(64'(gw_q) - 64'(term_q));
    z_val     = sat32(64'(zo_q) - 64'(inner_val));
    z_ovf     = ovf32(64'(zo_q) - 64'(inner_val));
    z64       = 64'(z_q);
    l1_64     = $signed({33'd0, l1_q});
    in_band   = (z64 <= l1_64) && (z64 >= -l1_64);
  end

  // Sequencer: state, clear sweep, output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // Load the result once the output register is free, else drop it when taken.
      if ((state_q == ST_OUT) && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
        out_q       <= '{weight: wnew_q, became_nonzero: bn_q, saturated: sat_q};
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == DEPTH_LAST) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_QUOT;
          end
        end
        ST_QUOT:      state_q <= ST_MOD;
        ST_MOD:       state_q <= ST_READ;
        ST_READ:      state_q <= ST_LOAD;
        ST_LOAD:      state_q <= (op_q == OP_READ) ? ST_OUT : ST_L2MUL;
        ST_L2MUL:     state_q <= ST_GW;
        ST_GW:        state_q <= ST_SQS;
        ST_SQS:       state_q <= ST_SQG;
        ST_SQG:       state_q <= ST_SUM;
        ST_SUM:       state_q <= ST_SQRT_GO;
        ST_SQRT_GO:   state_q <= ST_SQRT_WAIT;
        ST_SQRT_WAIT: if (sqrt_done) state_q <= ST_DIV1_GO;
        ST_DIV1_GO:   state_q <= ST_DIV1_WAIT;
        ST_DIV1_WAIT: if (div_done) state_q <= ST_TERM_MUL;
        ST_TERM_MUL:  state_q <= ST_TERM;
        ST_TERM:      state_q <= ST_ZST;
        ST_ZST:       state_q <= ST_THR;
        ST_THR:       state_q <= in_band ? ST_WRITE : ST_WMUL;
        ST_WMUL:      state_q <= ST_DIVW_GO;
        ST_DIVW_GO:   state_q <= (den_q == '0) ? ST_WRITE : ST_DIVW_WAIT;
        ST_DIVW_WAIT: if (div_done) state_q <= ST_WFIN;
        ST_WFIN:      state_q <= ST_WRITE;
        ST_WRITE:     state_q <= ST_OUT;
        ST_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    case (state_q)
      ST_IDLE: begin
        op_q  <= in_data_i.opcode;
        raw_q <= in_data_i.feature_index;
        g_q   <= in_data_i.gradient;
        sat_q <= 1'b0;
        bn_q  <= 1'b0;
      end
      ST_QUOT: quot_q <= quot_prod[29:20];
      ST_MOD: begin
        rem_q <= (mod_diff >= 31'(TABLE_DEPTH)) ? AW'(mod_diff - 31'(TABLE_DEPTH))
                                                : AW'(mod_diff);
      end
      ST_LOAD: begin
        zo_q   <= rd_data.z;
        so_q   <= rd_data.norm[31] ? '0 : rd_data.norm;
        wo_q   <= rd_data.w;
        wnew_q <= rd_data.w;
      end
      ST_GW: begin
        gw_q  <= gw_val;
        sat_q <= sat_q | m_ovf | gw_ovf;
      end
      ST_SQG: sq_q  <= 64'(prod_q);
      ST_SUM: rad_q <= sq_q + 64'(prod_q);
      ST_SQRT_WAIT: begin
        if (sqrt_done) begin
          ng_q  <= sqrt_root[31] ? QMAX32 : $signed(sqrt_root);
          sat_q <= sat_q | sqrt_root[31];
        end
      end
      ST_DIV1_WAIT: begin
        if (div_done) begin
          if (div_quo > 64'(QMAX64)) begin
            ratio_q <= QMAX32;
            sat_q   <= 1'b1;
          end else begin
            ratio_q <= $signed(div_quo[31:0]);
          end
        end
      end
      ST_TERM: begin
        term_q <= term_val;
        sat_q  <= sat_q | term_ovf;
      end
      ST_ZST: begin
        z_q   <= z_val;
        sat_q <= sat_q | inner_ovf | z_ovf;
      end
      ST_THR: begin
        zd_q   <= (z64 > 64'sd0) ? 32'(z64 - l1_64) : 32'(z64 + l1_64);
        den_q  <= {1'b0, beta_q} + ng_q;
        wnew_q <= '0;
      end
      ST_DIVW_GO: begin
        // Zero step denominator: clamp toward the sign of zd.
        if (den_q == '0) begin
          sat_q  <= 1'b1;
          wnew_q <= zd_q[31] ? QMIN32 : QMAX32;
        end
      end
      ST_WFIN: begin
        if (!zd_q[31]) begin
          if (div_quo > 64'd2147483647) begin
            wnew_q <= QMAX32;
            sat_q  <= 1'b1;
          end else begin
            wnew_q <= $signed(div_quo[31:0]);
          end
        end else begin
          if (div_quo > 64'd2147483648) begin
            wnew_q <= QMIN32;
            sat_q  <= 1'b1;
          end else begin
            wnew_q <= $signed(32'(-div_quo));
          end
        end
      end
      ST_WRITE: bn_q <= (wo_q == '0) && (wnew_q != '0);
      default: ;
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Table writes happen only during the sweep or an update write-back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_CLEAR) || (state_q == ST_WRITE && op_q == OP_UPDATE))
    else $error("table written outside sweep or write-back");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_done |-> state_q == ST_SQRT_WAIT)
    else $error("square root finished while sequencer not waiting");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV1_WAIT) || (state_q == ST_DIVW_WAIT))
    else $error("divider finished while sequencer not waiting");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !out_data_o.became_nonzero || (out_data_o.weight != '0))
    else $error("became_nonzero flagged with zero weight");

endmodule
